@@ rtl/sro_pkg.sv @@
// shared types and constants for the swept rectangle outline unit
package sro_pkg;

  localparam int MAX_EDGES  = 8;
  localparam int IDX_BITS   = 3;
  localparam int CNT_BITS   = 4;
  localparam int COORD_BITS = 32;

  typedef enum logic [1:0] {
    SHAPE_BOX  = 2'd0,
    SHAPE_DIAG = 2'd1,
    SHAPE_CROSS = 2'd2,
    SHAPE_PART = 2'd3
  } shape_t;

  // input beat: previous box then current box
  typedef struct packed {
    logic signed [COORD_BITS-1:0] prev_left;
    logic signed [COORD_BITS-1:0] prev_top;
    logic signed [COORD_BITS-1:0] prev_right;
    logic signed [COORD_BITS-1:0] prev_bottom;
    logic signed [COORD_BITS-1:0] cur_left;
    logic signed [COORD_BITS-1:0] cur_top;
    logic signed [COORD_BITS-1:0] cur_right;
    logic signed [COORD_BITS-1:0] cur_bottom;
  } pair_beat_t;

  // output beat: one outline segment
  typedef struct packed {
    logic [IDX_BITS-1:0]          edge_index;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [IDX_BITS-1:0]          prev_edge;
    logic [IDX_BITS-1:0]          next_edge;
    logic [CNT_BITS-1:0]          edge_count;
    logic                         last_edge;
  } seg_beat_t;

endpackage

@@ rtl/swept_rect_outline_unit.sv @@
// top level of the swept rectangle outline unit
// usage:
//   in_ channel carries one rectangle pair (previous and current box) per beat
//   out_ channel carries one outline edge per beat, 4 to 8 beats per pair,
//   in edge index order, last_edge set on the final edge of the run
//   a pair accepted into an empty unit passes the queue write, then the
//   output register, before its first edge shows
//   throughput: one edge per cycle while out_stall is low; the back end's
//   edge walk sets this
//   a two-entry queue between the classifier and the edge walker lets a new
//   pair be taken while the previous one is still being emitted
//   in_stall rises only when the queue is full
//   when out_stall is high the current edge holds and the walk pauses
//   reset empties the queue, drops out_valid and sets the edge walk back to index 0
module swept_rect_outline_unit import sro_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  pair_beat_t in_pair,
  output logic out_valid,
  input  logic out_stall,
  output seg_beat_t out_seg
);

  logic signed [COORD_BITS-1:0] fx [MAX_EDGES], fy [MAX_EDGES];
  logic [CNT_BITS-1:0] fn;
  shape_t fshape;

  logic signed [COORD_BITS-1:0] mx_r [2][MAX_EDGES], my_r [2][MAX_EDGES];
  logic [CNT_BITS-1:0] mn_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop;

  sro_front u_front (
    .a_l(in_pair.prev_left), .a_t(in_pair.prev_top),
    .a_r(in_pair.prev_right), .a_b(in_pair.prev_bottom),
    .b_l(in_pair.cur_left), .b_t(in_pair.cur_top),
    .b_r(in_pair.cur_right), .b_b(in_pair.cur_bottom),
    .px(fx), .py(fy), .n(fn), .shape(fshape)
  );

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall && (fshape == SHAPE_BOX || fshape == SHAPE_DIAG ||
                fshape == SHAPE_CROSS || fshape == SHAPE_PART);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
    if (push) begin
      mx_r[wp_r] <= fx; my_r[wp_r] <= fy; mn_r[wp_r] <= fn;
    end
  end

  sro_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(cnt_r != 2'd0), .q_pop(pop),
    .qx(mx_r[rp_r]), .qy(my_r[rp_r]), .qn(mn_r[rp_r]),
    .o_valid(out_valid), .o_stall(out_stall),
    .o_beat(out_seg)
  );

endmodule

@@ rtl/sro_front.sv @@
// front end: classifies a rectangle pair and builds the outline vertex list
module sro_front import sro_pkg::*; (
  input  logic signed [COORD_BITS-1:0] a_l, a_t, a_r, a_b,
  input  logic signed [COORD_BITS-1:0] b_l, b_t, b_r, b_b,
  output logic signed [COORD_BITS-1:0] px [MAX_EDGES],
  output logic signed [COORD_BITS-1:0] py [MAX_EDGES],
  output logic [CNT_BITS-1:0]  n,
  output shape_t               shape
);

  logic signed [COORD_BITS-1:0] vax [4], vay [4], vbx [4], vby [4];
  logic signed [COORD_BITS-1:0] pl, pt, pr, pb, ql, qt, qr, qb;
  logic signed [COORD_BITS-1:0] ppx [4], ppy [4], qqx [4], qqy [4];
  logic [1:0] k, kd, ki, ko;
  logic [2:0] s;
  logic [2:0] j;
  logic swp, swc;

  function automatic logic [1:0] cmp3(input logic signed [COORD_BITS-1:0] x,
                                      input logic signed [COORD_BITS-1:0] y);
    return (x < y) ? 2'd0 : ((x > y) ? 2'd2 : 2'd1);
  endfunction

  always_comb begin
    vax[0] = a_l; vay[0] = a_t; vax[1] = a_r; vay[1] = a_t;
    vax[2] = a_r; vay[2] = a_b; vax[3] = a_l; vay[3] = a_b;
    vbx[0] = b_l; vby[0] = b_t; vbx[1] = b_r; vby[1] = b_t;
    vbx[2] = b_r; vby[2] = b_b; vbx[3] = b_l; vby[3] = b_b;
    for (int i = 0; i < MAX_EDGES; i++) begin
      px[i] = '0;
      py[i] = '0;
    end
    n = 4'd4;
    shape = SHAPE_BOX;
    kd = 2'd0; ki = 2'd0; ko = 2'd0; k = 2'd0; s = 3'd7; j = 3'd0;
    swc = a_l < b_l;
    pl = swc ? b_l : a_l; pt = swc ? b_t : a_t; pr = swc ? b_r : a_r; pb = swc ? b_b : a_b;
    ql = swc ? a_l : b_l; qt = swc ? a_t : b_t; qr = swc ? a_r : b_r; qb = swc ? a_b : b_b;
    swp = (b_t <= a_t && a_b <= b_b && (a_l >= b_l || a_r <= b_r)) ||
          (b_l <= a_l && a_r <= b_r && (a_t >= b_t || a_b <= b_b));
    for (int i = 0; i < 4; i++) begin
      ppx[i] = swp ? vbx[i] : vax[i]; ppy[i] = swp ? vby[i] : vay[i];
      qqx[i] = swp ? vax[i] : vbx[i]; qqy[i] = swp ? vay[i] : vby[i];
    end
    if ((a_l == b_l && a_r == b_r) || (a_t == b_t && a_b == b_b) ||
        (a_l <= b_l && a_t <= b_t && b_r <= a_r && b_b <= a_b) ||
        (b_l <= a_l && b_t <= a_t && a_r <= b_r && a_b <= b_b)) begin
      shape = SHAPE_BOX;
      n = 4'd4;
      px[0] = (a_l < b_l) ? a_l : b_l; py[0] = (a_t < b_t) ? a_t : b_t;
      px[1] = (a_r > b_r) ? a_r : b_r; py[1] = py[0];
      px[2] = px[1]; py[2] = (a_b > b_b) ? a_b : b_b;
      px[3] = px[0]; py[3] = py[2];
    end else if (cmp3(a_l, b_l) == cmp3(a_r, b_r) && cmp3(a_t, b_t) == cmp3(a_b, b_b)) begin
      shape = SHAPE_DIAG;
      n = 4'd6;
      kd = (a_l < b_l) ? ((a_t < b_t) ? 2'd2 : 2'd1) :
           (a_l > b_l) ? ((a_t < b_t) ? 2'd3 : 2'd0) : 2'd0;
      for (int i = 0; i < 3; i++) begin
        ki = kd + 2'(i) + 2'd1;
        px[i] = vax[ki]; py[i] = vay[ki];
        ko = kd + 2'd3 + 2'(i);
        px[i+3] = vbx[ko]; py[i+3] = vby[ko];
      end
    end else if ((a_l != b_l || (a_t != b_t && a_b != b_b)) &&
                 (a_r != b_r || (a_t != b_t && a_b != b_b)) &&
                 ql < pl && pr < qr && pt < qt && qb < pb) begin
      shape = SHAPE_CROSS;
      n = 4'd8;
      px[0] = ql; py[0] = qt; px[1] = pl; py[1] = pt;
      px[2] = pr; py[2] = pt; px[3] = qr; py[3] = qt;
      px[4] = qr; py[4] = qb; px[5] = pr; py[5] = pb;
      px[6] = pl; py[6] = pb; px[7] = ql; py[7] = qb;
    end else begin
      shape = SHAPE_PART;
      k = (qqx[1] > ppx[1]) ? 2'd2 : (qqy[2] > ppy[2]) ? 2'd3 :
          (qqx[0] < ppx[0]) ? 2'd0 : (qqy[0] < ppy[0]) ? 2'd1 : 2'd0;
      if (ppy[0] == qqy[0])
        s = (k == 2'd2) ? 3'd3 : (k == 2'd0) ? 3'd0 : 3'd7;
      else if (ppy[2] == qqy[2])
        s = (k == 2'd2) ? 3'd0 : (k == 2'd0) ? 3'd3 : 3'd7;
      else if (ppx[0] == qqx[0])
        s = (k == 2'd3) ? 3'd0 : (k == 2'd1) ? 3'd3 : 3'd7;
      else if (ppx[1] == qqx[1])
        s = (k == 2'd3) ? 3'd3 : (k == 2'd1) ? 3'd0 : 3'd7;
      j = 3'd0;
      for (int i = 0; i < 4; i++) begin
        if (3'(i) != s) begin
          ki = k + 2'(i);
          px[j] = ppx[ki]; py[j] = ppy[ki];
          j = j + 3'd1;
        end
      end
      for (int i = 0; i < 2; i++) begin
        ko = k + 2'd3 + 2'(i);
        px[j] = qqx[ko]; py[j] = qqy[ko];
        j = j + 3'd1;
      end
      n = {1'b0, j};
    end
  end

endmodule

@@ rtl/sro_back.sv @@
// back end: walks a queued outline and emits one edge per beat
module sro_back import sro_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic signed [COORD_BITS-1:0] qx [MAX_EDGES],
  input  logic signed [COORD_BITS-1:0] qy [MAX_EDGES],
  input  logic [CNT_BITS-1:0] qn,
  output logic                o_valid,
  input  logic                o_stall,
  output seg_beat_t           o_beat
);

  logic [IDX_BITS-1:0] i_r, i_nxt;
  logic [IDX_BITS-1:0] e, p;
  logic last, adv;

  always_comb begin
    e = (i_r == '0) ? IDX_BITS'(qn - 4'd1) : i_r - IDX_BITS'(1);
    last = ({1'b0, i_r} == qn - 4'd1);
    p = last ? '0 : i_r + IDX_BITS'(1);
    adv = q_valid && (!o_valid || !o_stall);
    q_pop = adv && last;
    i_nxt = adv ? (last ? '0 : i_r + IDX_BITS'(1)) : i_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      o_valid <= 1'b0;
    end else begin
      i_r <= i_nxt;
      if (adv) o_valid <= 1'b1;
      else if (!o_stall) o_valid <= 1'b0;
    end
    if (adv) begin
      o_beat.edge_index <= i_r; o_beat.prev_edge <= p; o_beat.next_edge <= e;
      o_beat.start_x <= qx[i_r]; o_beat.start_y <= qy[i_r];
      o_beat.end_x <= qx[e]; o_beat.end_y <= qy[e];
      o_beat.edge_count <= qn; o_beat.last_edge <= last;
    end
  end

endmodule

@@ rtl/sro_checker.sv @@
// port-level checks for the swept rectangle outline unit
module sro_checker import sro_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic [IDX_BITS-1:0] out_edge_index,
  input logic [CNT_BITS-1:0] out_edge_count,
  input logic out_last_edge
);

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_edge_count >= 4'd4 && out_edge_count <= 4'd8)) else $error("bad count");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_edge == ({1'b0, out_edge_index} == out_edge_count - 4'd1)))
    else $error("bad last flag");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_edge) ##1 out_valid |->
      out_edge_index == $past(out_edge_index) + 3'd1) else $error("edge order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_edge_index))) else $error("stall hold");

endmodule

bind swept_rect_outline_unit sro_checker u_sro_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_edge_index(out_seg.edge_index), .out_edge_count(out_seg.edge_count),
  .out_last_edge(out_seg.last_edge)
);

@@ dv/tb_top.sv @@
// self-checking testbench for the swept rectangle outline unit
module tb_top import sro_pkg::*; ();

  typedef logic signed [31:0] coord_t;

  typedef struct {
    coord_t l, t, r, b;
  } rect_t;

  typedef struct {
    rect_t prev_box, cur_box;
  } rect_pair_t;

  typedef struct {
    logic [IDX_BITS-1:0] edge_index;
    coord_t start_x, start_y, end_x, end_y;
    logic [IDX_BITS-1:0] prev_edge, next_edge;
    logic [CNT_BITS-1:0] edge_count;
    logic last_edge;
  } outline_seg_t;

  class outline_scoreboard;
    outline_seg_t pending_segs[$];
    int fails;

    function coord_t corner_x(rect_t r, int i);
      return (i == 0 || i == 3) ? r.l : r.r;
    endfunction

    function coord_t corner_y(rect_t r, int i);
      return (i < 2) ? r.t : r.b;
    endfunction

    function int order3(coord_t a, coord_t b);
      return a < b ? -1 : (a > b ? 1 : 0);
    endfunction

    function bit encloses(rect_t o, rect_t i);
      return o.l <= i.l && o.t <= i.t && i.r <= o.r && i.b <= o.b;
    endfunction

    function void note_pair(rect_pair_t pr);
      rect_t a, b, p, q;
      coord_t vx[8], vy[8];
      int n, k, s, j, e;
      outline_seg_t sg;
      a = pr.prev_box;
      b = pr.cur_box;
      n = 0;
      if ((a.l == b.l && a.r == b.r) || (a.t == b.t && a.b == b.b) ||
          encloses(a, b) || encloses(b, a)) begin
        p.l = a.l < b.l ? a.l : b.l;
        p.t = a.t < b.t ? a.t : b.t;
        p.r = a.r > b.r ? a.r : b.r;
        p.b = a.b > b.b ? a.b : b.b;
        for (int i = 0; i < 4; i++) begin
          vx[i] = corner_x(p, i);
          vy[i] = corner_y(p, i);
        end
        n = 4;
      end else if (order3(a.l, b.l) == order3(a.r, b.r) &&
                   order3(a.t, b.t) == order3(a.b, b.b)) begin
        k = a.l < b.l ? (a.t < b.t ? 2 : 1) :
            a.l > b.l ? (a.t < b.t ? 3 : 0) : 0;
        for (int i = 0; i < 3; i++) begin
          vx[i] = corner_x(a, (k + i + 1) & 3);
          vy[i] = corner_y(a, (k + i + 1) & 3);
          vx[i+3] = corner_x(b, (k + 3 + i) & 3);
          vy[i+3] = corner_y(b, (k + 3 + i) & 3);
        end
        n = 6;
      end else begin
        if ((a.l != b.l || (a.t != b.t && a.b != b.b)) &&
            (a.r != b.r || (a.t != b.t && a.b != b.b))) begin
          p = a;
          q = b;
          if (a.l < b.l) begin
            p = b;
            q = a;
          end
          if (q.l < p.l && p.r < q.r && p.t < q.t && q.b < p.b) begin
            vx[0] = q.l; vy[0] = q.t; vx[1] = p.l; vy[1] = p.t;
            vx[2] = p.r; vy[2] = p.t; vx[3] = q.r; vy[3] = q.t;
            vx[4] = q.r; vy[4] = q.b; vx[5] = p.r; vy[5] = p.b;
            vx[6] = p.l; vy[6] = p.b; vx[7] = q.l; vy[7] = q.b;
            n = 8;
          end
        end
        if (n == 0) begin
          p = a;
          q = b;
          if ((b.t <= a.t && a.b <= b.b && (a.l >= b.l || a.r <= b.r)) ||
              (b.l <= a.l && a.r <= b.r && (a.t >= b.t || a.b <= b.b))) begin
            p = b;
            q = a;
          end
          k = q.r > p.r ? 2 : q.b > p.b ? 3 : q.l < p.l ? 0 : q.t < p.t ? 1 : 0;
          s = p.t == q.t ? (k == 2 ? 3 : k == 0 ? 0 : -1) :
              p.b == q.b ? (k == 2 ? 0 : k == 0 ? 3 : -1) :
              p.l == q.l ? (k == 3 ? 0 : k == 1 ? 3 : -1) :
              p.r == q.r ? (k == 3 ? 3 : k == 1 ? 0 : -1) : -1;
          j = 0;
          for (int i = 0; i < 4; i++) begin
            if (i != s) begin
              vx[j] = corner_x(p, (k + i) & 3);
              vy[j] = corner_y(p, (k + i) & 3);
              j++;
            end
          end
          for (int i = 0; i < 2; i++) begin
            vx[j+i] = corner_x(q, (k + 3 + i) & 3);
            vy[j+i] = corner_y(q, (k + 3 + i) & 3);
          end
          n = j + 2;
        end
      end
      for (int i = 0; i < n; i++) begin
        e = (n + i - 1) % n;
        sg.edge_index = IDX_BITS'(i);
        sg.start_x = vx[i];
        sg.start_y = vy[i];
        sg.end_x = vx[e];
        sg.end_y = vy[e];
        sg.prev_edge = IDX_BITS'((i + 1) % n);
        sg.next_edge = IDX_BITS'(e);
        sg.edge_count = CNT_BITS'(n);
        sg.last_edge = (i == n - 1);
        pending_segs.push_back(sg);
      end
    endfunction

    function void cmp_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        fails++;
      end
    endfunction

    function void check_seg(outline_seg_t got);
      outline_seg_t w;
      if (pending_segs.size() == 0) begin
        $error("edge beat with none outstanding: index %0d", got.edge_index);
        fails++;
        return;
      end
      w = pending_segs.pop_front();
      cmp_field("edge_index", w.edge_index, got.edge_index);
      cmp_field("start_x", w.start_x, got.start_x);
      cmp_field("start_y", w.start_y, got.start_y);
      cmp_field("end_x", w.end_x, got.end_x);
      cmp_field("end_y", w.end_y, got.end_y);
      cmp_field("prev_edge", w.prev_edge, got.prev_edge);
      cmp_field("next_edge", w.next_edge, got.next_edge);
      cmp_field("edge_count", w.edge_count, got.edge_count);
      cmp_field("last_edge", w.last_edge, got.last_edge);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  pair_beat_t in_pair = '0;
  logic out_valid;
  logic out_stall = 0;
  seg_beat_t out_seg;

  outline_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  swept_rect_outline_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin
    outline_seg_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.edge_index = out_seg.edge_index;
      got.start_x = out_seg.start_x;
      got.start_y = out_seg.start_y;
      got.end_x = out_seg.end_x;
      got.end_y = out_seg.end_y;
      got.prev_edge = out_seg.prev_edge;
      got.next_edge = out_seg.next_edge;
      got.edge_count = out_seg.edge_count;
      got.last_edge = out_seg.last_edge;
      sb.check_seg(got);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("** swept_rect_outline_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_pair(rect_pair_t pr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 0;
    end
    @(negedge clk);
    in_valid = 1;
    in_pair.prev_left = pr.prev_box.l;
    in_pair.prev_top = pr.prev_box.t;
    in_pair.prev_right = pr.prev_box.r;
    in_pair.prev_bottom = pr.prev_box.b;
    in_pair.cur_left = pr.cur_box.l;
    in_pair.cur_top = pr.cur_box.t;
    in_pair.cur_right = pr.cur_box.r;
    in_pair.cur_bottom = pr.cur_box.b;
    do @(posedge clk); while (in_stall);
    sb.note_pair(pr);
  endtask

  task automatic send_rects(coord_t al, at, ar, ab, bl, bt, br, bb);
    rect_pair_t pr;
    pr.prev_box = '{al, at, ar, ab};
    pr.cur_box = '{bl, bt, br, bb};
    send_pair(pr);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_segs.size() != 0) @(posedge clk);
  endtask

  function automatic rect_t jitter_rect(coord_t base);
    rect_t r;
    r.l = base + $urandom_range(0, 6) - 3;
    r.t = base + $urandom_range(0, 6) - 3;
    r.r = r.l + $urandom_range(0, 8);
    r.b = r.t + $urandom_range(0, 8);
    if ($urandom_range(0, 15) == 0) r.r = r.l - $urandom_range(1, 4);
    return r;
  endfunction

  function automatic rect_pair_t random_pair();
    rect_pair_t pr;
    coord_t base;
    int mv;
    if ($urandom_range(0, 7) == 0) begin
      pr.prev_box = '{$urandom, $urandom, $urandom, $urandom};
      pr.cur_box = '{$urandom, $urandom, $urandom, $urandom};
      return pr;
    end
    case ($urandom_range(0, 3))
      0: base = $urandom;
      1: base = 32'sh7fff_fff0;
      2: base = 32'sh8000_0008;
      default: base = $urandom_range(0, 40) - 20;
    endcase
    pr.prev_box = jitter_rect(base);
    pr.cur_box = pr.prev_box;
    mv = $urandom_range(0, 3);
    if (mv == 0) pr.cur_box = jitter_rect(base);
    else begin
      pr.cur_box.l += $urandom_range(0, 6) - 3;
      pr.cur_box.r += $urandom_range(0, 6) - 3;
      pr.cur_box.t += $urandom_range(0, 6) - 3;
      pr.cur_box.b += $urandom_range(0, 6) - 3;
    end
    return pr;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send_rects(0, 0, 10, 10, 0, 0, 10, 10);
    send_rects(0, 0, 10, 10, 2, 2, 8, 8);
    send_rects(2, 2, 8, 8, 0, 0, 10, 10);
    send_rects(0, 0, 10, 10, 0, 5, 10, 15);
    send_rects(0, 0, 10, 10, 5, 0, 15, 10);
    send_rects(0, 0, 10, 10, 5, 5, 15, 15);
    send_rects(0, 0, 10, 10, 5, -5, 15, 5);
    send_rects(0, 0, 10, 10, -5, 5, 5, 15);
    send_rects(0, 0, 10, 10, -5, -5, 5, 5);
    send_rects(0, 3, 10, 7, 3, 0, 7, 10);
    send_rects(3, 0, 7, 10, 0, 3, 10, 7);
    send_rects(0, 0, 10, 10, 5, 2, 15, 8);
    send_rects(0, 0, 10, 10, 5, 0, 15, 8);
    send_rects(0, 0, 10, 10, 2, 5, 8, 15);
    send_rects(0, 0, 10, 10, -5, 2, 5, 10);
    send_rects(0, 0, 10, 10, 2, -5, 10, 5);
    send_rects(10, 10, 0, 0, 5, 5, 15, 15);
    send_rects(0, 0, 10, 10, 15, 5, 5, 15);
    send_rects(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
               0, 0, 1, 1);
    send_rects(32'sh8000_0000, 32'sh8000_0000, 0, 0,
               -1, -1, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_rects(-1, -1, -1, -1, 32'sh7fff_ffff, 32'sh8000_0000,
               32'sh8000_0000, 32'sh7fff_ffff);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 15 : 0;
      recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 15 : 0;
      for (int n = 0; n < 70; n++) send_pair(random_pair());
      wait_drained();
    end
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);

    if (sb.fails == 0 && sb.pending_segs.size() == 0)
      $display("** swept_rect_outline_unit: PASSED **");
    else
      $display("** swept_rect_outline_unit: FAILED **");
    $finish;
  end
endmodule

@@ swept_rect_outline_unit.f @@
rtl/sro_pkg.sv
rtl/sro_front.sv
rtl/sro_back.sv
rtl/swept_rect_outline_unit.sv
rtl/sro_checker.sv
dv/tb_top.sv
